[sv/quadratic_root_solver_assert.svh]
// assertion macros for the quadratic root solver
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define QRS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("quadratic root solver assertion failed");

// next-cycle implication, clocked on clk_i, off during reset
`define QRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("quadratic root solver assertion failed");

`endif

[sv/qrs_pkg.sv]
// shared constants for the quadratic root solver
package qrs_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int EPS_BITS      = 16;

  localparam logic [EPS_BITS-1:0] EPS_RESET = 16'd1;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_INF  = 2'd3;

endpackage

[sv/qrs_sqrt.sv]
// pipelined integer square root, one root bit per stage
module qrs_sqrt #(
  parameter int DW = 65,
  parameter int PW = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     vld_i,
  input  logic [DW-1:0]            d_i,
  input  logic [PW-1:0]            pay_i,
  output logic                     vld_o,
  output logic [(DW+1)/2-1:0]      root_o,
  output logic [PW-1:0]            pay_o
);
  localparam int RW  = (DW + 1) / 2;
  localparam int RMW = 2 * RW + 1;

  logic [RMW-1:0] rem_q  [RW];
  logic [RW-1:0]  root_q [RW];
  logic [PW-1:0]  pay_q  [RW];
  logic           vld_q  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int I = RW - 1 - k;
    logic [RMW-1:0] rem_c;
    logic [RMW-1:0] term;
    logic [RW-1:0]  root_c;
    logic [PW-1:0]  pay_c;
    logic           vld_c;

    if (k == 0) begin : g_first
      assign rem_c  = RMW'(d_i);
      assign root_c = '0;
      assign pay_c  = pay_i;
      assign vld_c  = vld_i;
    end else begin : g_rest
      assign rem_c  = rem_q[k-1];
      assign root_c = root_q[k-1];
      assign pay_c  = pay_q[k-1];
      assign vld_c  = vld_q[k-1];
    end

    assign term = (RMW'(root_c) << (I + 1)) | (RMW'(1) << (2 * I));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pay_q[k] <= pay_c;
        if (rem_c >= term) begin
          rem_q[k]  <= rem_c - term;
          root_q[k] <= root_c | (RW'(1) << I);
        end else begin
          rem_q[k]  <= rem_c;
          root_q[k] <= root_c;
        end
      end
    end
  end

  assign vld_o  = vld_q[RW-1];
  assign root_o = root_q[RW-1];
  assign pay_o  = pay_q[RW-1];

endmodule

[sv/qrs_div.sv]
// pipelined restoring divider, (num << FRAC) / den, one quotient bit per stage
module qrs_div #(
  parameter int NW   = 34,
  parameter int DNW  = 33,
  parameter int FRAC = 16,
  parameter int PW   = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic [NW-1:0]        num_i,
  input  logic [DNW-1:0]       den_i,
  input  logic [PW-1:0]        pay_i,
  output logic                 vld_o,
  output logic [NW+FRAC-1:0]   quo_o,
  output logic [PW-1:0]        pay_o
);
  localparam int QW = NW + FRAC;

  logic [DNW-1:0] rem_q [QW];
  logic [QW-1:0]  quo_q [QW];
  logic [NW-1:0]  num_q [QW];
  logic [DNW-1:0] den_q [QW];
  logic [PW-1:0]  pay_q [QW];
  logic           vld_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int I = QW - 1 - k;
    logic [DNW-1:0] rem_c;
    logic [QW-1:0]  quo_c;
    logic [NW-1:0]  num_c;
    logic [DNW-1:0] den_c;
    logic [PW-1:0]  pay_c;
    logic           vld_c;
    logic           bit_c;
    logic [DNW:0]   trial;

    if (k == 0) begin : g_first
      assign rem_c = '0;
      assign quo_c = '0;
      assign num_c = num_i;
      assign den_c = den_i;
      assign pay_c = pay_i;
      assign vld_c = vld_i;
    end else begin : g_rest
      assign rem_c = rem_q[k-1];
      assign quo_c = quo_q[k-1];
      assign num_c = num_q[k-1];
      assign den_c = den_q[k-1];
      assign pay_c = pay_q[k-1];
      assign vld_c = vld_q[k-1];
    end

    if (I >= FRAC) begin : g_num_bit
      assign bit_c = num_c[I-FRAC];
    end else begin : g_zero_bit
      assign bit_c = 1'b0;
    end

    assign trial = {rem_c, bit_c};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k] <= num_c;
        den_q[k] <= den_c;
        pay_q[k] <= pay_c;
        if (trial >= {1'b0, den_c}) begin
          rem_q[k] <= DNW'(trial - {1'b0, den_c});
          quo_q[k] <= quo_c | (QW'(1) << I);
        end else begin
          rem_q[k] <= trial[DNW-1:0];
          quo_q[k] <= quo_c;
        end
      end
    end
  end

  assign vld_o = vld_q[QW-1];
  assign quo_o = quo_q[QW-1];
  assign pay_o = pay_q[QW-1];

endmodule

[sv/quadratic_root_solver.sv]
// Quadratic root solver: takes a, b, c of a*x^2+b*x+c=0 as signed fixed point
// (WORD_BITS wide, FRAC_BITS fraction bits) and returns a root count with up
// to two saturated roots. Fully pipelined: one beat in and one beat out per
// cycle while the output is not stalled. Most pipeline stages lie in the
// bit-per-stage square root and the two bit-per-stage dividers. A stall at
// the output freezes the whole pipeline; in_ready_o drops only while a
// result is held and out_ready_i is low. near_zero_epsilon (eps_q) is
// written through cfg_we_i/cfg_wdata_i; the user must write it only while
// idle, as the block itself does not enforce this.
module quadratic_root_solver #(
  parameter int WORD_BITS = qrs_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [qrs_pkg::EPS_BITS-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [WORD_BITS-1:0]   coef_a_i,
  input  logic signed [WORD_BITS-1:0]   coef_b_i,
  input  logic signed [WORD_BITS-1:0]   coef_c_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    root_count_o,
  output logic signed [WORD_BITS-1:0]   root_one_o,
  output logic signed [WORD_BITS-1:0]   root_two_o,
  output logic                          overflow_o
);
  import qrs_pkg::*;

  `include "quadratic_root_solver_assert.svh"

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int DW  = 2 * W + 1;
  localparam int RW  = (DW + 1) / 2;
  localparam int NW  = W + 2;
  localparam int DNW = W + 1;
  localparam int QW  = NW + F;
  localparam int CW  = DW + EPS_BITS + F;
  localparam int SPW = 6 + 3 * W;

  logic [EPS_BITS-1:0] eps_q;
  logic                en;
  logic                out_vld_q;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EPS_RESET;
    end else if (cfg_we_i) begin
      eps_q <= cfg_wdata_i;
    end
  end

  // stage 1: sign and magnitude
  logic         s1_vld_q;
  logic         s1_an_q, s1_bn_q, s1_cn_q;
  logic [W-1:0] s1_am_q, s1_bm_q, s1_cm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_an_q <= coef_a_i[W-1];
      s1_bn_q <= coef_b_i[W-1];
      s1_cn_q <= coef_c_i[W-1];
      s1_am_q <= coef_a_i[W-1] ? W'(-coef_a_i) : W'(coef_a_i);
      s1_bm_q <= coef_b_i[W-1] ? W'(-coef_b_i) : W'(coef_b_i);
      s1_cm_q <= coef_c_i[W-1] ? W'(-coef_c_i) : W'(coef_c_i);
    end
  end

  // stage 2: b*b and a*c
  logic           s2_vld_q;
  logic           s2_an_q, s2_bn_q, s2_cn_q;
  logic [W-1:0]   s2_am_q, s2_bm_q, s2_cm_q;
  logic [2*W-1:0] s2_bb_q, s2_ac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_an_q <= s1_an_q;
      s2_bn_q <= s1_bn_q;
      s2_cn_q <= s1_cn_q;
      s2_am_q <= s1_am_q;
      s2_bm_q <= s1_bm_q;
      s2_cm_q <= s1_cm_q;
      s2_bb_q <= s1_bm_q * s1_bm_q;
      s2_ac_q <= s1_am_q * s1_cm_q;
    end
  end

  // stage 3: discriminant and classification
  logic [DW-1:0] p_x, q4, disc;
  logic          dneg, dnear, a_zero, b_small, c_small, lin;
  logic [1:0]    cnt;

  always_comb begin
    p_x     = DW'(s2_bb_q);
    q4      = DW'({s2_ac_q, 2'b00});
    dneg    = 1'b0;
    if (s2_an_q != s2_cn_q) begin
      disc = p_x + q4;
    end else if (p_x >= q4) begin
      disc = p_x - q4;
    end else begin
      disc = '0;
      dneg = 1'b1;
    end
    dnear   = CW'(disc) <= (CW'(eps_q) << F);
    a_zero  = s2_am_q == '0;
    b_small = s2_bm_q <= W'(eps_q);
    c_small = s2_cm_q <= W'(eps_q);
    lin     = 1'b0;
    if (a_zero) begin
      if (b_small) begin
        cnt = c_small ? CNT_INF : CNT_NONE;
      end else begin
        cnt = CNT_ONE;
        lin = 1'b1;
      end
    end else if (dneg) begin
      cnt = CNT_NONE;
    end else if (dnear) begin
      cnt = CNT_ONE;
    end else begin
      cnt = CNT_TWO;
    end
  end

  logic           s3_vld_q;
  logic [DW-1:0]  s3_disc_q;
  logic [SPW-1:0] s3_pay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_disc_q <= disc;
      s3_pay_q  <= {cnt, lin, s2_an_q, s2_bn_q, s2_cn_q, s2_am_q, s2_bm_q, s2_cm_q};
    end
  end

  // square root pipeline
  logic           sq_vld;
  logic [RW-1:0]  sq_root;
  logic [SPW-1:0] sq_pay;

  qrs_sqrt #(
    .DW (DW),
    .PW (SPW)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s3_vld_q),
    .d_i    (s3_disc_q),
    .pay_i  (s3_pay_q),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .pay_o  (sq_pay)
  );

  // stage 4: numerators and denominator
  logic [1:0]     p_cnt;
  logic           p_lin, p_an, p_bn, p_cn;
  logic [W-1:0]   p_am, p_bm, p_cm;
  logic [NW-1:0]  bmx, sx, n_sum, n_bs, n_sb, m1, m2, n1;
  logic           sa, bge, s1, s2, neg1, neg2;
  logic [DNW-1:0] den;

  assign {p_cnt, p_lin, p_an, p_bn, p_cn, p_am, p_bm, p_cm} = sq_pay;

  always_comb begin
    bmx   = NW'(p_bm);
    sx    = NW'(sq_root);
    n_sum = bmx + sx;
    n_bs  = bmx - sx;
    n_sb  = sx - bmx;
    bge   = bmx >= sx;
    sa    = !p_bn;
    if (!sa) begin
      m1 = n_sum;
      s1 = 1'b0;
    end else if (bge) begin
      m1 = n_bs;
      s1 = 1'b1;
    end else begin
      m1 = n_sb;
      s1 = 1'b0;
    end
    if (sa) begin
      m2 = n_sum;
      s2 = 1'b1;
    end else if (bge) begin
      m2 = n_bs;
      s2 = 1'b0;
    end else begin
      m2 = n_sb;
      s2 = 1'b1;
    end
    neg2 = s2 != p_an;
    if (p_lin) begin
      n1   = NW'(p_cm);
      den  = DNW'(p_bm);
      neg1 = p_cn == p_bn;
    end else if (p_cnt == CNT_ONE) begin
      n1   = bmx;
      den  = {p_am, 1'b0};
      neg1 = p_bn == p_an;
    end else begin
      n1   = m1;
      den  = {p_am, 1'b0};
      neg1 = s1 != p_an;
    end
  end

  logic           s4_vld_q;
  logic [1:0]     s4_cnt_q;
  logic           s4_neg1_q, s4_neg2_q;
  logic [NW-1:0]  s4_n1_q, s4_n2_q;
  logic [DNW-1:0] s4_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (en) begin
      s4_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_cnt_q  <= p_cnt;
      s4_neg1_q <= neg1;
      s4_neg2_q <= neg2;
      s4_n1_q   <= n1;
      s4_n2_q   <= m2;
      s4_den_q  <= den;
    end
  end

  // two divider pipelines in lockstep
  logic          d1_vld, d2_vld;
  logic [QW-1:0] d1_quo, d2_quo;
  logic [2:0]    d1_pay;
  logic          d2_neg;

  qrs_div #(
    .NW   (NW),
    .DNW  (DNW),
    .FRAC (F),
    .PW   (3)
  ) u_div_one (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s4_vld_q),
    .num_i  (s4_n1_q),
    .den_i  (s4_den_q),
    .pay_i  ({s4_cnt_q, s4_neg1_q}),
    .vld_o  (d1_vld),
    .quo_o  (d1_quo),
    .pay_o  (d1_pay)
  );

  qrs_div #(
    .NW   (NW),
    .DNW  (DNW),
    .FRAC (F),
    .PW   (1)
  ) u_div_two (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s4_vld_q),
    .num_i  (s4_n2_q),
    .den_i  (s4_den_q),
    .pay_i  (s4_neg2_q),
    .vld_o  (d2_vld),
    .quo_o  (d2_quo),
    .pay_o  (d2_neg)
  );

  // saturate to the word range, result is {overflow, value}
  function automatic logic [W:0] sat_word(input logic neg, input logic [QW-1:0] quo);
    logic [QW-1:0] lim;
    logic [QW-1:0] mag;
    logic          ovf;
    lim = (QW'(1) << (W - 1)) - QW'(!neg);
    ovf = quo > lim;
    mag = ovf ? lim : quo;
    return {ovf, neg ? W'(-mag) : W'(mag)};
  endfunction

  logic [W:0] sat1, sat2;
  logic [1:0] f_cnt;
  logic       f_ovf;

  assign f_cnt = d1_pay[2:1];
  assign sat1  = sat_word(d1_pay[0], d1_quo);
  assign sat2  = sat_word(d2_neg, d2_quo);
  assign f_ovf = ((f_cnt == CNT_ONE) && sat1[W]) ||
                 ((f_cnt == CNT_TWO) && (sat1[W] || sat2[W]));

  logic [1:0]   out_cnt_q;
  logic [W-1:0] out_r1_q, out_r2_q;
  logic         out_ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= d1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_cnt_q <= f_cnt;
      out_ovf_q <= f_ovf;
      out_r1_q  <= ((f_cnt == CNT_ONE) || (f_cnt == CNT_TWO)) ? sat1[W-1:0] : '0;
      out_r2_q  <= (f_cnt == CNT_TWO) ? sat2[W-1:0] : '0;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign root_count_o = out_cnt_q;
  assign root_one_o   = out_r1_q;
  assign root_two_o   = out_r2_q;
  assign overflow_o   = out_ovf_q;

  `QRS_ASSERT_NOW(a_div_lockstep, 1'b1, d1_vld == d2_vld)
  `QRS_ASSERT_NOW(a_stall_only_when_held, !in_ready_o, out_valid_o && !out_ready_i)
  `QRS_ASSERT_NOW(a_no_root_is_zero,
    out_valid_o && (root_count_o == CNT_NONE || root_count_o == CNT_INF),
    root_one_o == '0 && root_two_o == '0 && !overflow_o)
  `QRS_ASSERT_NOW(a_second_root_only_for_two, out_valid_o && root_count_o != CNT_TWO,
    root_two_o == '0)

endmodule
